@@ hw/rtl/stt_pkg.sv @@
// Shared types and constants for the software timer table.
// Holds the command, status and state codes and the item structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int TIME_W              = 32;
  localparam int MAX_RESULTS         = 16;
  localparam int DEF_SLOT_COUNT      = 16;
  localparam int DEF_PRIORITY_LEVELS = 4;
  localparam int DEF_TAG_BITS        = 16;

  typedef enum logic [2:0] {
    CMD_CREATE   = 3'd0,
    CMD_PAUSE    = 3'd1,
    CMD_CONTINUE = 3'd2,
    CMD_DELETE   = 3'd3,
    CMD_RECONFIG = 3'd4,
    CMD_PROCESS  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADPRIO = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FIND,
    S_RD,
    S_EV,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [7:0]        slot_select;
    logic [15:0]       handler_tag;
    logic [TIME_W-1:0] period_value;
    logic [TIME_W-1:0] phase_offset;
    logic              time_base;
    logic [3:0]        priority_level;
    logic [TIME_W-1:0] now_millis;
    logic [TIME_W-1:0] now_micros;
  } req_t;

  typedef struct packed {
    logic [3:0]  slot_number;
    logic [1:0]  status;
    logic        fired;
    logic [15:0] fired_tag;
    logic [3:0]  fired_priority;
    logic        last;
  } rsp_t;

  // Per-slot control bits kept beside the times.
  typedef struct packed {
    logic       paused;
    logic       base;
    logic [3:0] prio;
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/stt_div.sv @@
// Restoring bit-serial divider that returns the 32-bit remainder.
// One quotient bit per cycle; uses stt_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module stt_div
  import stt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output logic                   busy,
  output logic [TIME_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(TIME_W);

  logic [CNT_W-1:0]  count;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] rem_next;
  logic [TIME_W-1:0] dvd;
  logic [TIME_W-1:0] dvs;
  logic [TIME_W:0]   trial;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem, dvd[TIME_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = TIME_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[TIME_W-1:0];
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CNT_W'(TIME_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[TIME_W-2:0], 1'b0};
    end
  end

  assign remainder = rem;

endmodule

`default_nettype wire

@@ hw/rtl/software_timer_table.sv @@
// Top level of the software timer table: slot store, sequencer, output register.
// Depends on stt_pkg and stt_div.
//
// Usage: one command item enters on req/req_valid/req_ready and gives one or
// more result items on rsp/rsp_valid/rsp_ready. Every command except process
// gives one result with last set. Process gives one result per fired slot in
// slot order (at most 16), last set on the final one, or a single empty
// result when nothing fires.
// The sequencer works on one item at a time and req_ready is high only while
// it is idle. Create searches the slots in order for a free one; continue
// of a paused periodic slot that is past due waits for the remainder divider
// to skip missed periods; process reads and checks one slot at a time
// through the single read port of the slot store.
// Results leave through an output register, so a new item is accepted while a
// result still waits. When the receiver stalls with a result held, the
// sequencer waits at its next result; nothing is dropped.
// Reset clears all valid bits at once: every slot reads as free, running and
// in milliseconds on the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_table
  import stt_pkg::*;
#(
  parameter int SLOT_COUNT      = DEF_SLOT_COUNT,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
  parameter int TAG_BITS        = DEF_TAG_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int NF_W  = $clog2(MAX_RESULTS + 1);

  state_t state;
  state_t state_next;
  req_t   req_q;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [NF_W-1:0]  nfire;
  logic [NF_W-1:0]  nfire_next;

  // Slot store.
  logic [TAG_BITS-1:0] mem_tag [SLOT_COUNT];
  logic [TIME_W-1:0]   mem_due [SLOT_COUNT];
  logic [TIME_W-1:0]   mem_per [SLOT_COUNT];
  ctl_t                mem_ctl [SLOT_COUNT];
  logic [TAG_BITS-1:0] rd_tag;
  logic [TIME_W-1:0]   rd_due;
  logic [TIME_W-1:0]   rd_per;
  ctl_t                rd_ctl;
  logic [SLOT_COUNT-1:0] vld;
  logic [SLOT_COUNT-1:0] occ;

  // Write controls.
  logic                wr_en;
  logic [TAG_BITS-1:0] wr_tag;
  logic [TIME_W-1:0]   wr_due;
  logic [TIME_W-1:0]   wr_per;
  ctl_t                wr_ctl;
  logic                wr_occ;
  logic                clr_en;

  // Held fire result of a process scan.
  logic        pend_valid;
  logic        pend_valid_next;
  logic [3:0]  pend_slot;
  logic [15:0] pend_tag;
  logic [3:0]  pend_prio;
  logic        pend_load;

  // Result output.
  logic emit;
  logic can_emit;
  rsp_t rsp_next;

  // Divider link.
  logic              div_start;
  logic              div_busy;
  logic [TIME_W-1:0] div_rem;

  // Decoded request and masked slot entry.
  logic [TAG_BITS-1:0] tag_in;
  logic                in_range;
  logic                bad_prio;
  logic [IDX_W-1:0]    sel_idx;
  logic                last_idx;
  logic [TIME_W-1:0]   now_req;
  logic [TAG_BITS-1:0] e_tag;
  logic [TIME_W-1:0]   e_due;
  logic [TIME_W-1:0]   e_per;
  ctl_t                e_ctl;
  logic [TIME_W-1:0]   now_e;
  logic                fire;

  assign tag_in   = TAG_BITS'(req_q.handler_tag);
  assign in_range = {1'b0, req_q.slot_select} < 9'(SLOT_COUNT);
  assign bad_prio = {1'b0, req_q.priority_level} >= 5'(PRIORITY_LEVELS);
  assign sel_idx  = IDX_W'(req_q.slot_select);
  assign last_idx = (idx == IDX_W'(SLOT_COUNT - 1));
  assign now_req  = req_q.time_base ? req_q.now_micros : req_q.now_millis;
  assign e_tag    = vld[idx] ? rd_tag : '0;
  assign e_due    = vld[idx] ? rd_due : '0;
  assign e_per    = vld[idx] ? rd_per : '0;
  assign e_ctl    = vld[idx] ? rd_ctl : '0;
  assign now_e    = e_ctl.base ? req_q.now_micros : req_q.now_millis;
  assign fire     = occ[idx] && !e_ctl.paused && (now_e >= e_due);
  assign can_emit = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  stt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (now_e - e_due),
    .divisor   (e_per),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        case (req_q.command)
          CMD_CREATE: begin
            if (!bad_prio) state_next = S_FIND;
            else if (can_emit) state_next = S_IDLE;
          end
          CMD_PAUSE, CMD_CONTINUE: begin
            if (in_range) state_next = S_RD;
            else if (can_emit) state_next = S_IDLE;
          end
          CMD_RECONFIG: begin
            if (in_range && !bad_prio && occ[sel_idx]) state_next = S_RD;
            else if (can_emit) state_next = S_IDLE;
          end
          CMD_PROCESS: state_next = S_RD;
          default: begin
            if (can_emit) state_next = S_IDLE;
          end
        endcase
      end
      S_FIND: begin
        if ((!occ[idx] || last_idx) && can_emit) state_next = S_IDLE;
      end
      S_RD: state_next = S_EV;
      S_EV: begin
        if (req_q.command == CMD_PROCESS) begin
          if (!fire || !pend_valid || can_emit) begin
            if (last_idx || (fire && (nfire + 1'b1 == NF_W'(MAX_RESULTS)))) begin
              state_next = S_FIN;
            end else begin
              state_next = S_RD;
            end
          end
        end else if (req_q.command == CMD_CONTINUE && e_ctl.paused &&
                     e_per != '0 && now_e >= e_due) begin
          state_next = S_DIV;
        end else if (can_emit) begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (!div_busy && can_emit) state_next = S_IDLE;
      end
      S_FIN: begin
        if (can_emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath controls and results for each state.
  always_comb begin
    idx_next        = idx;
    nfire_next      = nfire;
    pend_valid_next = pend_valid;
    pend_load       = 1'b0;
    wr_en           = 1'b0;
    wr_tag          = e_tag;
    wr_due          = e_due;
    wr_per          = e_per;
    wr_ctl          = e_ctl;
    wr_occ          = occ[idx];
    clr_en          = 1'b0;
    div_start       = 1'b0;
    emit            = 1'b0;
    rsp_next        = '0;
    rsp_next.last   = 1'b1;
    case (state)
      S_IDLE: begin
        idx_next        = '0;
        nfire_next      = '0;
        pend_valid_next = 1'b0;
      end
      S_CHECK: begin
        case (req_q.command)
          CMD_CREATE: begin
            if (bad_prio) begin
              emit            = can_emit;
              rsp_next.status = ST_BADPRIO;
            end
          end
          CMD_PAUSE, CMD_CONTINUE: begin
            idx_next = sel_idx;
            if (!in_range) begin
              emit            = can_emit;
              rsp_next.status = ST_IGNORED;
            end
          end
          CMD_DELETE: begin
            idx_next = sel_idx;
            emit     = can_emit;
            if (in_range) begin
              rsp_next.slot_number = 4'(sel_idx);
              rsp_next.status      = ST_OK;
            end else begin
              rsp_next.status = ST_IGNORED;
            end
          end
          CMD_RECONFIG: begin
            idx_next = sel_idx;
            if (!in_range) begin
              emit            = can_emit;
              rsp_next.status = ST_IGNORED;
            end else if (bad_prio) begin
              emit                 = can_emit;
              rsp_next.slot_number = 4'(sel_idx);
              rsp_next.status      = ST_BADPRIO;
            end else if (!occ[sel_idx]) begin
              emit                 = can_emit;
              rsp_next.slot_number = 4'(sel_idx);
              rsp_next.status      = ST_IGNORED;
            end
          end
          CMD_PROCESS: idx_next = '0;
          default: begin
            emit            = can_emit;
            rsp_next.status = ST_IGNORED;
          end
        endcase
      end
      S_FIND: begin
        if (!occ[idx]) begin
          emit                 = can_emit;
          wr_en                = can_emit;
          wr_tag               = tag_in;
          wr_due               = now_req + req_q.phase_offset;
          wr_per               = req_q.period_value;
          wr_ctl               = '{paused: 1'b0, base: req_q.time_base,
                                   prio: req_q.priority_level};
          wr_occ               = (tag_in != '0);
          rsp_next.slot_number = 4'(idx);
          rsp_next.status      = ST_OK;
        end else if (last_idx) begin
          emit            = can_emit;
          rsp_next.status = ST_FULL;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_EV: begin
        rsp_next.slot_number = 4'(idx);
        if (req_q.command == CMD_PROCESS) begin
          if (fire && (!pend_valid || can_emit)) begin
            emit                    = pend_valid;
            rsp_next.slot_number    = pend_slot;
            rsp_next.status         = ST_OK;
            rsp_next.fired          = 1'b1;
            rsp_next.fired_tag      = pend_tag;
            rsp_next.fired_priority = pend_prio;
            rsp_next.last           = 1'b0;
            pend_load               = 1'b1;
            pend_valid_next         = 1'b1;
            nfire_next              = nfire + 1'b1;
            if (e_per == '0) begin
              clr_en = 1'b1;
            end else begin
              wr_en  = 1'b1;
              wr_due = e_due + e_per;
            end
            if (!last_idx) idx_next = idx + 1'b1;
          end else if (!fire && !last_idx) begin
            idx_next = idx + 1'b1;
          end
        end else if (req_q.command == CMD_PAUSE) begin
          emit            = can_emit;
          wr_en           = can_emit;
          wr_ctl.paused   = 1'b1;
          rsp_next.status = ST_OK;
        end else if (req_q.command == CMD_RECONFIG) begin
          emit            = can_emit;
          wr_en           = can_emit;
          wr_tag          = (tag_in != '0) ? tag_in : e_tag;
          wr_due          = now_req + req_q.phase_offset;
          wr_per          = req_q.period_value;
          wr_ctl          = '{paused: 1'b0, base: req_q.time_base,
                              prio: req_q.priority_level};
          rsp_next.status = ST_OK;
        end else begin
          // Continue: only a paused periodic slot is resumed; any other slot is ignored.
          if (!e_ctl.paused || e_per == '0) begin
            emit            = can_emit;
            rsp_next.status = ST_IGNORED;
          end else if (now_e < e_due) begin
            emit            = can_emit;
            wr_en           = can_emit;
            wr_ctl.paused   = 1'b0;
            rsp_next.status = ST_OK;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_DIV: begin
        // New due time is now minus the remainder plus one period.
        rsp_next.slot_number = 4'(idx);
        rsp_next.status      = ST_OK;
        if (!div_busy) begin
          emit          = can_emit;
          wr_en         = can_emit;
          wr_due        = now_e - div_rem + e_per;
          wr_ctl.paused = 1'b0;
        end
      end
      S_FIN: begin
        emit = can_emit;
        if (pend_valid) begin
          rsp_next.slot_number    = pend_slot;
          rsp_next.fired          = 1'b1;
          rsp_next.fired_tag      = pend_tag;
          rsp_next.fired_priority = pend_prio;
        end
        rsp_next.status = ST_OK;
        if (can_emit) pend_valid_next = 1'b0;
      end
      default: begin
        idx_next = idx;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      nfire      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      nfire      <= nfire_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Captured request and held fire result.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) req_q <= req;
    if (pend_load) begin
      pend_slot <= 4'(idx);
      pend_tag  <= 16'(e_tag);
      pend_prio <= e_ctl.prio;
    end
  end

  // Slot store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_tag[idx] <= wr_tag;
      mem_due[idx] <= wr_due;
      mem_per[idx] <= wr_per;
      mem_ctl[idx] <= wr_ctl;
    end
    rd_tag <= mem_tag[idx];
    rd_due <= mem_due[idx];
    rd_per <= mem_per[idx];
    rd_ctl <= mem_ctl[idx];
  end

  // Valid and occupied bits per slot. A delete acts on the selected slot
  // directly, since the slot index is not loaded until after the check.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      occ <= '0;
    end else if (clr_en) begin
      vld[idx] <= 1'b0;
      occ[idx] <= 1'b0;
    end else if (emit && state == S_CHECK && req_q.command == CMD_DELETE &&
                 in_range) begin
      vld[sel_idx] <= 1'b0;
      occ[sel_idx] <= 1'b0;
    end else if (wr_en) begin
      vld[idx] <= 1'b1;
      occ[idx] <= wr_occ;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) rsp <= rsp_next;
  end

  // An occupied slot always has a written entry.
  a_occ_vld : assert property (@(posedge clk) disable iff (rst) (occ & ~vld) == '0)
    else $error("occupied slot without a valid entry");

  // Error results end their item and never report a fire.
  a_err_last : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last && !rsp.fired)
    else $error("error result not final");

  // A process never reports more fires than the limit.
  a_nfire : assert property (@(posedge clk) disable iff (rst)
    nfire <= NF_W'(MAX_RESULTS))
    else $error("fire count over limit");

  // The divider only runs while the sequencer waits for it.
  a_div : assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DIV)
    else $error("divider busy outside continue");

endmodule

`default_nettype wire
